// ===== hdl/smf_pkg.sv =====
// Shared types and constants for the substring match finder.
// Depends on nothing; every other file in hdl/ imports it.
`default_nettype none

package smf_pkg;

    // Pattern storage: four 64-bit words, eight bytes each
    localparam int unsigned PATTERN_WORDS = 4;
    localparam int unsigned PATTERN_BYTES = PATTERN_WORDS * 8;
    localparam int unsigned LEN_W         = 6;
    localparam int unsigned FIELD_W       = 16;

    // Configuration port geometry
    localparam int unsigned CFG_ADDR_W = 6;
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned REG_IDX_W  = 3;

    // Register indexes (byte address = 8 * index)
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_WORD_0 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_WORD_1 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_WORD_2 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_WORD_3 = 3'd4;

    // Input beat
    typedef struct packed {
        logic [7:0] text_byte;
        logic       text_last;
    } text_beat_t;

    // Output beat
    typedef struct packed {
        logic               match_found;
        logic [FIELD_W-1:0] match_start;
        logic [FIELD_W-1:0] match_total;
        logic               text_done;
    } match_beat_t;

    // Pattern view handed from the register block to the cell row.
    // aligned[j] is the pattern byte that window position j (newest = 0)
    // must equal; active[j] marks positions inside the pattern length.
    typedef struct packed {
        logic [LEN_W-1:0]                  len;
        logic [PATTERN_BYTES-1:0][7:0]     aligned;
        logic [PATTERN_BYTES-1:0]          active;
    } cfg_view_t;

endpackage

`default_nettype wire

// ===== hdl/smf_cell.sv =====
// One window cell: holds one text byte, passes it on each beat, and
// compares the byte it is about to take against its pattern byte. Uses smf_pkg.
`default_nettype none

module smf_cell (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       shift,
    input  wire logic [7:0] byte_in,
    input  wire logic [7:0] pat,
    input  wire logic       act,
    output logic      [7:0] byte_out,
    output logic            eq
);
    import smf_pkg::*;

    logic [7:0] byte_reg;

    // Window byte, moves one cell older per accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= 8'h00;
        end
        else if (shift)
        begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out = byte_reg;

    // Compare on the shifted view; positions past the pattern always agree
    assign eq = !act || (byte_in == pat);

endmodule

`default_nettype wire

// ===== hdl/smf_cfg.sv =====
// Configuration registers behind the APB-style port, plus the pattern
// view aligned to window positions. Uses smf_pkg.
`default_nettype none

module smf_cfg (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [smf_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [smf_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic      [smf_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                                 pready,
    output smf_pkg::cfg_view_t                   view
);
    import smf_pkg::*;

    logic [LEN_W-1:0]                       len_reg, len_next;
    logic [PATTERN_WORDS-1:0][63:0]         word_reg, word_next;
    logic [PATTERN_BYTES-1:0][7:0]          aligned_reg, aligned_next;
    logic [PATTERN_BYTES-1:0]               active_reg, active_next;
    logic                                   wr;
    logic [REG_IDX_W-1:0]                   idx;
    logic [PATTERN_BYTES*8-1:0]             pat_vec;
    logic [PATTERN_BYTES*8-1:0]             rev_vec;
    logic [LEN_W-1:0]                       sh;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = paddr[CFG_ADDR_W-1:3];

    // Register write decode
    always_comb
    begin
        len_next  = len_reg;
        word_next = word_reg;
        if (wr)
        begin
            case (idx)
                REG_PATTERN_LENGTH: len_next     = pwdata[LEN_W-1:0];
                REG_PATTERN_WORD_0: word_next[0] = pwdata;
                REG_PATTERN_WORD_1: word_next[1] = pwdata;
                REG_PATTERN_WORD_2: word_next[2] = pwdata;
                REG_PATTERN_WORD_3: word_next[3] = pwdata;
                default:            len_next     = len_reg;
            endcase
        end
    end

    // Align the pattern to window positions: position j needs byte len-1-j.
    // Reverse the byte order, then shift right by 32-len bytes.
    always_comb
    begin
        pat_vec = word_next;
        for (int i = 0; i < PATTERN_BYTES; i++)
        begin
            rev_vec[8*i +: 8] = pat_vec[8*(PATTERN_BYTES-1-i) +: 8];
        end
        sh           = LEN_W'(PATTERN_BYTES) - len_next;
        aligned_next = rev_vec >> {sh, 3'b000};
        for (int j = 0; j < PATTERN_BYTES; j++)
        begin
            active_next[j] = (LEN_W'(j) < len_next);
        end
    end

    // Registers track the next config so the view is never stale
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg     <= LEN_W'(1);
            word_reg    <= '0;
            aligned_reg <= '0;
            active_reg  <= PATTERN_BYTES'(1);
        end
        else
        begin
            len_reg     <= len_next;
            word_reg    <= word_next;
            aligned_reg <= aligned_next;
            active_reg  <= active_next;
        end
    end

    // Read back
    always_comb
    begin
        case (idx)
            REG_PATTERN_LENGTH: prdata = CFG_DATA_W'(len_reg);
            REG_PATTERN_WORD_0: prdata = word_reg[0];
            REG_PATTERN_WORD_1: prdata = word_reg[1];
            REG_PATTERN_WORD_2: prdata = word_reg[2];
            REG_PATTERN_WORD_3: prdata = word_reg[3];
            default:            prdata = '0;
        endcase
    end

    assign view.len     = len_reg;
    assign view.aligned = aligned_reg;
    assign view.active  = active_reg;

endmodule

`default_nettype wire

// ===== hdl/substring_match_finder_top.sv =====
// Top level of the streaming substring match finder.
// Depends on smf_pkg, smf_cfg and smf_cell.
`default_nettype none

// Takes one text byte per cycle while text_stall is low and returns one result
// beat per text byte, in the cycle after the byte is accepted. The window is a
// row of MAX_PATTERN cells that shift the text along; every cell compares its
// incoming byte with its aligned pattern byte in parallel, so sustained
// throughput is one byte per clock while the output is not stalled. The result
// sits in an output register; text_stall rises only when that register is full
// and the downstream side stalls. Pattern registers are 64 bits wide at byte
// address 8 * index; pattern_length 0 or above min(MAX_PATTERN, 32) never
// matches. Counters saturate at 2^COUNT_WIDTH - 1, reported position and count
// clip at 2^min(COUNT_WIDTH, 16) - 1; counters restart after the text_last beat.
module substring_match_finder_top #(
    parameter int unsigned MAX_PATTERN = 32,
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [smf_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [smf_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic      [smf_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                                 pready,
    input  wire logic                            text_valid,
    output logic                                 text_stall,
    input  wire smf_pkg::text_beat_t             text_beat,
    output logic                                 match_valid,
    input  wire logic                            match_stall,
    output smf_pkg::match_beat_t                 match_beat
);
    import smf_pkg::*;

    localparam int unsigned MAX_LEN  = (MAX_PATTERN < PATTERN_BYTES) ? MAX_PATTERN
                                                                     : PATTERN_BYTES;
    localparam int unsigned CLIP_INT = (COUNT_WIDTH > FIELD_W) ? ((1 << FIELD_W) - 1)
                                                               : ((1 << COUNT_WIDTH) - 1);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [COUNT_WIDTH-1:0] CLIP_MAX  = COUNT_WIDTH'(CLIP_INT);

    cfg_view_t              view;
    logic                   accept;
    logic [7:0]             link [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] eq;
    logic                   len_ok;
    logic [COUNT_WIDTH-1:0] len_ext;
    logic [COUNT_WIDTH-1:0] bytes_reg, bytes_next, bytes_inc;
    logic [COUNT_WIDTH-1:0] matches_reg, matches_next, matches_inc;
    logic [COUNT_WIDTH-1:0] start;
    logic                   hit;
    logic                   valid_reg;
    match_beat_t            beat_reg, beat_next;

    // Configuration registers
    smf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .view    (view)
    );

    // Handshake: output register frees when empty or drained
    assign text_stall = valid_reg && match_stall;
    assign accept     = text_valid && !text_stall;

    // Row of window cells, newest byte enters cell 0
    assign link[0] = text_beat.text_byte;

    for (genvar j = 0; j < MAX_PATTERN; j++)
    begin : g_cell
        logic [7:0] pat_j;
        logic       act_j;

        if (j < PATTERN_BYTES)
        begin : g_pat
            assign pat_j = view.aligned[j];
            assign act_j = view.active[j];
        end
        else
        begin : g_nopat
            assign pat_j = 8'h00;
            assign act_j = 1'b0;
        end

        if (j + 1 < MAX_PATTERN)
        begin : g_mid
            smf_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift    (accept),
                .byte_in  (link[j]),
                .pat      (pat_j),
                .act      (act_j),
                .byte_out (link[j+1]),
                .eq       (eq[j])
            );
        end
        else
        begin : g_end
            smf_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift    (accept),
                .byte_in  (link[j]),
                .pat      (pat_j),
                .act      (act_j),
                .byte_out (),
                .eq       (eq[j])
            );
        end
    end

    // Match decision and counters
    always_comb
    begin
        len_ok      = (view.len != '0) && (view.len <= LEN_W'(MAX_LEN));
        len_ext     = COUNT_WIDTH'(view.len);
        bytes_inc   = (bytes_reg == COUNT_MAX) ? COUNT_MAX : bytes_reg + 1'b1;
        hit         = len_ok && (bytes_inc >= len_ext) && (&eq);
        matches_inc = (matches_reg == COUNT_MAX) ? COUNT_MAX : matches_reg + 1'b1;
        matches_inc = hit ? matches_inc : matches_reg;
        start       = hit ? (bytes_inc - len_ext + 1'b1) : '0;

        beat_next.match_found = hit;
        beat_next.match_start = (start > CLIP_MAX) ? FIELD_W'(CLIP_INT)
                                                   : FIELD_W'(start);
        beat_next.match_total = (matches_inc > CLIP_MAX) ? FIELD_W'(CLIP_INT)
                                                         : FIELD_W'(matches_inc);
        beat_next.text_done   = text_beat.text_last;

        if (text_beat.text_last)
        begin
            bytes_next   = '0;
            matches_next = '0;
        end
        else
        begin
            bytes_next   = bytes_inc;
            matches_next = matches_inc;
        end
    end

    // Counter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_reg   <= '0;
            matches_reg <= '0;
        end
        else if (accept)
        begin
            bytes_reg   <= bytes_next;
            matches_reg <= matches_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (!match_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            beat_reg <= beat_next;
        end
    end

    assign match_valid = valid_reg;
    assign match_beat  = beat_reg;

endmodule

`default_nettype wire
